// ===== design/adrp_pkg.sv =====
// shared types and constants of the adrp add reference scanner
// no dependencies
package adrp_pkg;

  localparam logic [31:0] ADRP_MASK  = 32'h9F00_0000;
  localparam logic [31:0] ADRP_MATCH = 32'h9000_0000;
  localparam logic [31:0] ADD_MASK   = 32'h7F80_0000;
  localparam logic [31:0] ADD_MATCH  = 32'h1100_0000;

  localparam logic [1:0] STATUS_NONE   = 2'd0;
  localparam logic [1:0] STATUS_UNIQUE = 2'd1;
  localparam logic [1:0] STATUS_AMBIG  = 2'd2;

  localparam logic REG_REGION_BASE = 1'b0;
  localparam logic REG_TARGET      = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [63:0] pc;
    logic        is_adrp;
    logic [4:0]  rd;
    logic [20:0] adrp_imm;
    logic        is_add;
    logic [4:0]  rn;
    logic [23:0] add_imm;
    logic        last;
  } entry_t;

endpackage

// ===== design/adrp_front.sv =====
// front part: accepts instruction words, forms the word address and decodes
// depends on adrp_pkg
module adrp_front #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [31:0]      instruction_word,
  input  logic             final_word,
  input  logic [63:0]      region_base,
  output adrp_pkg::entry_t entry
);
  import adrp_pkg::*;

  logic [COUNT_WIDTH-1:0] word_count;
  logic [11:0]            add_field;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (take) begin
      if (final_word) begin
        word_count <= '0;
      end else begin
        word_count <= word_count + 1'b1;
      end
    end
  end

  assign add_field = instruction_word[21:10];

  always_comb begin
    entry          = '0;
    entry.pc       = region_base + (64'(word_count) << 2);
    entry.is_adrp  = (instruction_word & ADRP_MASK) == ADRP_MATCH;
    entry.rd       = instruction_word[4:0];
    entry.adrp_imm = {instruction_word[23:5], instruction_word[30:29]};
    entry.is_add   = (instruction_word & ADD_MASK) == ADD_MATCH;
    entry.rn       = instruction_word[9:5];
    entry.add_imm  = instruction_word[22] ? {add_field, 12'h000} : {12'h000, add_field};
    entry.last     = final_word;
  end

endmodule

// ===== design/adrp_queue.sv =====
// short queue of decoded words between front and back parts
// depends on adrp_pkg
module adrp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  adrp_pkg::entry_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output adrp_pkg::entry_t rd_data,
  output logic             valid
);
  import adrp_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full    = fill == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid   = fill != '0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== design/adrp_back.sv =====
// back part: page arithmetic, pair check, hit counting and result register
// depends on adrp_pkg
module adrp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  adrp_pkg::entry_t q_data,
  output logic             q_take,
  input  logic [63:0]      target_address,
  output logic [63:0]      reference_address,
  output logic [1:0]       match_status,
  output logic             empty,
  input  logic             pop
);
  import adrp_pkg::*;

  logic        pending;
  logic [4:0]  pend_rd;
  logic [63:0] pend_page;
  logic [63:0] pend_pc;
  logic [1:0]  hit_count;
  logic [63:0] hit_addr;
  logic        out_valid;

  logic        out_free;
  logic [63:0] page;
  logic        pair_hit;
  logic [1:0]  hit_count_next;
  logic [63:0] hit_addr_next;

  assign out_free = !out_valid || pop;
  assign q_take   = q_valid && (!q_data.last || out_free);
  assign empty    = !out_valid;

  assign page = {q_data.pc[63:12], 12'h000}
              + {{31{q_data.adrp_imm[20]}}, q_data.adrp_imm, 12'h000};

  assign pair_hit = pending && q_data.is_add && (q_data.rn == pend_rd)
                 && ((pend_page + 64'(q_data.add_imm)) == target_address);

  always_comb begin
    hit_count_next = hit_count;
    hit_addr_next  = hit_addr;
    if (pair_hit) begin
      if (hit_count == 2'd0) begin
        hit_addr_next = pend_pc;
      end
      if (hit_count != 2'd2) begin
        hit_count_next = hit_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      hit_count <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (q_take && q_data.last) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (q_take) begin
        if (q_data.last) begin
          pending   <= 1'b0;
          hit_count <= 2'd0;
        end else begin
          pending   <= q_data.is_adrp && (page != 64'd0);
          hit_count <= hit_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      pend_rd   <= q_data.rd;
      pend_page <= page;
      pend_pc   <= q_data.pc;
      hit_addr  <= hit_addr_next;
      if (q_data.last) begin
        case (hit_count_next)
          2'd0: begin
            reference_address <= 64'd0;
            match_status      <= STATUS_NONE;
          end
          2'd1: begin
            reference_address <= hit_addr_next;
            match_status      <= STATUS_UNIQUE;
          end
          default: begin
            reference_address <= 64'd0;
            match_status      <= STATUS_AMBIG;
          end
        endcase
      end
    end
  end

endmodule

// ===== design/adrp_add_reference_scanner_unit.sv =====
// path: a word is decoded and written into the queue when it is accepted, and later taken by the pair
// stage; the result of a final word is registered when the pair stage takes it from the queue
// throughput: one word per cycle; a final word waits in the queue while an earlier result
// is not popped, and the input stalls once the two queue slots fill
// reset: synchronous rst clears the word count, queue, scan state, result valid flag and
// both configuration registers; no clearing pass
module adrp_add_reference_scanner_unit #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic [31:0] instruction_word,
  input  logic        final_word,
  input  logic        push,
  output logic        full,
  output logic [63:0] reference_address,
  output logic [1:0]  match_status,
  output logic        empty,
  input  logic        pop
);
  import adrp_pkg::*;

  logic [63:0] region_base;
  logic [63:0] target_address;
  logic        cfg_write;
  logic        in_take;
  logic        q_valid;
  logic        q_take;
  entry_t      front_entry;
  entry_t      q_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_take   = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base    <= 64'd0;
      target_address <= 64'd0;
    end else if (cfg_write) begin
      case (paddr[3])
        REG_REGION_BASE: region_base    <= pwdata;
        REG_TARGET:      target_address <= pwdata;
        default:         region_base    <= region_base;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_REGION_BASE: prdata = region_base;
      REG_TARGET:      prdata = target_address;
      default:         prdata = 64'd0;
    endcase
  end

  adrp_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .take             (in_take),
    .instruction_word (instruction_word),
    .final_word       (final_word),
    .region_base      (region_base),
    .entry            (front_entry)
  );

  adrp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_take),
    .wr_data (front_entry),
    .full    (full),
    .rd_en   (q_take),
    .rd_data (q_data),
    .valid   (q_valid)
  );

  adrp_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .q_take            (q_take),
    .target_address    (target_address),
    .reference_address (reference_address),
    .match_status      (match_status),
    .empty             (empty),
    .pop               (pop)
  );

endmodule

// ===== test/adrp_scan_checker.sv =====
// checker for the adrp add reference scanner: watches the register port and both word
// channels, predicts every scan result and compares it field by field
// depends on adrp_pkg
module adrp_scan_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic [31:0] instruction_word,
  input  logic        final_word,
  input  logic        push,
  input  logic        full,
  input  logic [63:0] reference_address,
  input  logic [1:0]  match_status,
  input  logic        empty,
  input  logic        pop,
  output int          fail_count,
  output int          pending_results
);
  import adrp_pkg::*;

  typedef struct packed {
    logic [63:0] address;
    logic [1:0]  status;
  } scan_result_t;

  scan_result_t expected_results[$];

  logic [63:0] region_base_q;
  logic [63:0] target_q;
  logic [31:0] word_index;
  logic        pair_open;
  logic [4:0]  pair_reg;
  logic [63:0] pair_page;
  logic [63:0] pair_pc;
  logic [1:0]  hit_total;
  logic [63:0] first_hit_pc;

  task automatic restart_scan();
    word_index   = '0;
    pair_open    = 1'b0;
    pair_reg     = '0;
    pair_page    = '0;
    pair_pc      = '0;
    hit_total    = '0;
    first_hit_pc = '0;
  endtask

  task automatic scan_word(input logic [31:0] w, input logic last);
    logic [63:0]  pc;
    logic [63:0]  add_value;
    logic [63:0]  page;
    logic [20:0]  page_imm;
    scan_result_t outcome;
    pc = region_base_q + {30'b0, word_index, 2'b00};
    // second half: add immediate reading the register the adrp wrote
    if (pair_open && (w & ADD_MASK) == ADD_MATCH && w[9:5] == pair_reg) begin
      add_value = w[22] ? {40'b0, w[21:10], 12'b0} : {52'b0, w[21:10]};
      if (pair_page + add_value == target_q) begin
        if (hit_total == 2'd0) first_hit_pc = pair_pc;
        if (hit_total < 2'd2) hit_total = hit_total + 2'd1;
      end
    end
    // first half: a zero page never opens a pair
    pair_open = 1'b0;
    if ((w & ADRP_MASK) == ADRP_MATCH) begin
      page_imm = {w[23:5], w[30:29]};
      page = {pc[63:12], 12'b0} + {{31{page_imm[20]}}, page_imm, 12'b0};
      if (page != '0) begin
        pair_open = 1'b1;
        pair_reg  = w[4:0];
        pair_page = page;
        pair_pc   = pc;
      end
    end
    word_index = word_index + 32'd1;
    if (last) begin
      case (hit_total)
        2'd0: outcome = '{address: '0, status: STATUS_NONE};
        2'd1: outcome = '{address: first_hit_pc, status: STATUS_UNIQUE};
        default: outcome = '{address: '0, status: STATUS_AMBIG};
      endcase
      expected_results.push_back(outcome);
      restart_scan();
    end
  endtask

  always @(posedge clk) begin : monitor
    scan_result_t want;
    if (rst) begin
      region_base_q = '0;
      target_q = '0;
      restart_scan();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result with no word waiting: reference_address %h match_status %0d",
                 reference_address, match_status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (reference_address !== want.address) begin
            $error("reference_address expected %h actual %h", want.address, reference_address);
            fail_count++;
          end
          if (match_status !== want.status) begin
            $error("match_status expected %0d actual %0d", want.status, match_status);
            fail_count++;
          end
        end
      end
      if (push && !full) scan_word(instruction_word, final_word);
      if (psel && penable && pwrite && pready) begin
        case (paddr[3])
          REG_REGION_BASE: region_base_q = pwdata;
          REG_TARGET: target_q = pwdata;
          default: ;
        endcase
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== test/adrp_add_reference_scanner_unit_tb.sv =====
// testbench top for the adrp add reference scanner: clock, reset, register writes and
// instruction word stimulus, verdict; depends on adrp_pkg, the scanner and adrp_scan_checker
module adrp_add_reference_scanner_unit_tb;
  import adrp_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam int          WORD_TARGET = 1200;
  localparam logic [31:0] NOP_WORD    = 32'hD503_201F;
  localparam logic [31:0] SUB_FLAG    = 32'h4000_0000;
  localparam logic [31:0] SET_FLAGS   = 32'h2000_0000;

  typedef enum int {
    SPOIL_NONE, SPOIL_REG, SPOIL_IMM, SPOIL_SUB, SPOIL_FLAGS, SPOIL_SHIFT
  } spoil_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic [31:0] instruction_word = '0;
  logic        final_word = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] reference_address;
  logic [1:0]  match_status;
  logic        empty;
  logic        pop = 1'b0;

  int          fail_count;
  int          pending_results;
  int          stall_cycles = 0;
  int          words_sent = 0;
  int          scans_sent = 0;
  int          settings_used = 0;
  logic        quiet = 1'b0;
  logic [63:0] cfg_base = '0;
  logic [63:0] cfg_target = '0;
  logic [31:0] scan_words[$];

  adrp_add_reference_scanner_unit DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .instruction_word(instruction_word), .final_word(final_word),
    .push(push), .full(full),
    .reference_address(reference_address), .match_status(match_status),
    .empty(empty), .pop(pop)
  );

  adrp_scan_checker checker_i (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .instruction_word(instruction_word), .final_word(final_word),
    .push(push), .full(full),
    .reference_address(reference_address), .match_status(match_status),
    .empty(empty), .pop(pop),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    pop <= quiet || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[adrp_add_reference_scanner_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [31:0] adrp_word(input logic [4:0] rd, input logic [20:0] imm);
    return ADRP_MATCH | {1'b0, imm[1:0], 5'b0, imm[20:2], rd};
  endfunction

  function automatic logic [31:0] add_word(input logic [4:0] rn, input logic [11:0] imm,
                                           input logic sh);
    return ADD_MATCH | {1'($urandom), 8'b0, sh, imm, rn, 5'($urandom)};
  endfunction

  // adrp plus add forming the target from pc; false when the page is out of reach
  function automatic bit fit_pair(input logic [63:0] pc, input logic want_shift,
                                  output logic [31:0] w_adrp, output logic [31:0] w_add);
    logic [63:0] add_value;
    logic [63:0] span;
    logic [11:0] imm;
    logic        sh;
    logic [4:0]  rd;
    sh = want_shift && cfg_target[11:0] == 12'h000;
    imm = sh ? 12'($urandom) : cfg_target[11:0];
    add_value = sh ? {40'b0, imm, 12'b0} : {52'b0, imm};
    span = cfg_target - add_value - {pc[63:12], 12'b0};
    rd = 5'($urandom);
    w_adrp = adrp_word(rd, span[32:12]);
    w_add = add_word(rd, imm, sh);
    return span[63:32] == {32{span[32]}};
  endfunction

  task automatic add_pair(input spoil_t spoil, input logic want_shift);
    logic [31:0] first_w;
    logic [31:0] second_w;
    logic [63:0] pc;
    pc = cfg_base + 64'(scan_words.size()) * 64'd4;
    if (!fit_pair(pc, want_shift, first_w, second_w)) begin
      first_w = ADRP_MATCH | ($urandom & ~ADRP_MASK);
    end
    case (spoil)
      SPOIL_REG: second_w[9:5] = second_w[9:5] ^ 5'($urandom_range(1, 31));
      SPOIL_IMM: second_w[21:10] = second_w[21:10] + 12'd1;
      SPOIL_SUB: second_w = second_w | SUB_FLAG;
      SPOIL_FLAGS: second_w = second_w | SET_FLAGS;
      SPOIL_SHIFT: second_w[22] = ~second_w[22];
      default: ;
    endcase
    scan_words.push_back(first_w);
    scan_words.push_back(second_w);
  endtask

  task automatic fill_scan(input int len, input int hit_pct);
    int pick;
    while (scan_words.size() < len) begin
      pick = $urandom_range(0, 99);
      if (scan_words.size() + 1 < len && pick < hit_pct + 15) begin
        add_pair(pick < hit_pct ? SPOIL_NONE : spoil_t'($urandom_range(1, 5)),
                 1'($urandom));
      end else if (pick < hit_pct + 30) begin
        scan_words.push_back(ADRP_MATCH | ($urandom & ~ADRP_MASK));
      end else if (pick < hit_pct + 40) begin
        scan_words.push_back(ADD_MATCH | ($urandom & ~ADD_MASK));
      end else begin
        scan_words.push_back($urandom);
      end
    end
  endtask

  task automatic send_word(input logic [31:0] w, input logic last);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    instruction_word <= w;
    final_word <= last;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_scan();
    foreach (scan_words[i]) send_word(scan_words[i], i == scan_words.size() - 1);
    words_sent += scan_words.size();
    scans_sent++;
    scan_words.delete();
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_REGION_BASE) cfg_base = value;
    else cfg_target = value;
  endtask

  task automatic configure(input logic [63:0] base, input logic [63:0] target);
    write_reg(REG_REGION_BASE, base);
    write_reg(REG_TARGET, target);
    settings_used++;
  endtask

  initial begin : stimulus
    logic [63:0] base;
    logic [63:0] target;
    logic [31:0] r;
    int          len;
    int          hit_pct;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(64'h0000_0000_0040_0000, 64'h0000_0000_1234_5678);
    scan_words.push_back(32'h0000_0000);
    send_scan();
    add_pair(SPOIL_NONE, 1'b0);
    scan_words.push_back(32'hFFFF_FFFF);
    send_scan();
    add_pair(SPOIL_NONE, 1'b0);
    add_pair(SPOIL_NONE, 1'b0);
    scan_words.push_back(NOP_WORD);
    send_scan();
    add_pair(SPOIL_SUB, 1'b0);
    scan_words.push_back(NOP_WORD);
    send_scan();
    // adrp as the last word of the region
    scan_words.push_back(NOP_WORD);
    add_pair(SPOIL_NONE, 1'b0);
    void'(scan_words.pop_back());
    send_scan();
    // overlapping adrp ahead of a good pair
    scan_words.push_back(ADRP_MATCH | ($urandom & ~ADRP_MASK));
    add_pair(SPOIL_NONE, 1'b0);
    scan_words.push_back(NOP_WORD);
    send_scan();

    // zero page, page wrap onto a zero target, broken pair with a zero target
    settle();
    configure('0, '0);
    scan_words.push_back(adrp_word(5'd3, 21'h0));
    scan_words.push_back(add_word(5'd3, 12'h000, 1'b0));
    scan_words.push_back(adrp_word(5'd7, 21'h1F_FFFF));
    scan_words.push_back(add_word(5'd7, 12'h001, 1'b1));
    scan_words.push_back(adrp_word(5'd7, 21'h1F_FFFF));
    scan_words.push_back(NOP_WORD);
    send_scan();

    while (words_sent < WORD_TARGET) begin
      settle();
      quiet = words_sent >= 500 && words_sent < 700;
      r = $urandom;
      case ($urandom_range(0, 5))
        0: base = '0;
        1: base = 64'hFFFF_FFFF_FFFF_FFF0;
        2: base = {$urandom, $urandom};
        default: base = {$urandom, $urandom} & ~64'h3;
      endcase
      case ($urandom_range(0, 7))
        0: target = '0;
        1: target = '1;
        2: target = {$urandom, $urandom};
        3: target = base + 64'($urandom_range(0, 8191));
        4, 5: target = (base + {{32{r[31]}}, r}) & ~64'hFFF;
        default: target = base + {{32{r[31]}}, r};
      endcase
      configure(base, target);
      repeat ($urandom_range(1, 6)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 14);
        case ($urandom_range(0, 2))
          0: hit_pct = 0;
          1: hit_pct = 8;
          default: hit_pct = 25;
        endcase
        fill_scan(len, hit_pct);
        send_scan();
      end
    end
    quiet = 1'b0;
    settle();
    repeat (10) @(posedge clk);

    $display("scanned %0d instruction words in %0d regions under %0d register settings",
             words_sent, scans_sent, settings_used);
    if (fail_count == 0 && pending_results == 0) begin
      $display("[adrp_add_reference_scanner_unit] OK");
    end else begin
      $display("[adrp_add_reference_scanner_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/adrp_pkg.sv
design/adrp_front.sv
design/adrp_queue.sv
design/adrp_back.sv
design/adrp_add_reference_scanner_unit.sv
test/adrp_scan_checker.sv
test/adrp_add_reference_scanner_unit_tb.sv
